// ===== rtl/serial_frame_deframer_xor_defines.svh =====
// assertion macros for the serial frame deframer
// used by the rtl modules that carry assertions; needs clock and reset in scope
`ifndef SERIAL_FRAME_DEFRAMER_XOR_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_XOR_DEFINES_SVH

// condition holds at every edge out of reset
`define SFDX_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent holds whenever the antecedent holds
`define SFDX_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sfdx_pkg.sv =====
// shared types and constants of the serial frame deframer
// no dependencies
`default_nettype none

package sfdx_pkg;

   localparam logic [7:0] HDR1_BYTE = 8'hA5;
   localparam logic [7:0] HDR2_BYTE = 8'h5A;
   localparam logic [7:0] FOOT_BYTE = 8'hEE;

   localparam int DESC_DEPTH = 4;
   localparam int DESC_AW    = $clog2(DESC_DEPTH);
   localparam int DESC_CW    = $clog2(DESC_DEPTH + 1);

   typedef enum logic [2:0] {
      PS_HDR1 = 3'd0,
      PS_HDR2 = 3'd1,
      PS_LEN  = 3'd2,
      PS_DATA = 3'd3,
      PS_XOR  = 3'd4,
      PS_FOOT = 3'd5
   } parse_state_type;

   typedef struct packed {
      logic empty;
      logic full;
   } desc_status_type;

   typedef struct packed {
      logic rd;
      logic desc_pop;
   } back_req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [4:0] byte_index;
      logic [5:0] frame_length;
      logic       checksum_ok;
      logic       last;
   } out_item_type;

endpackage

`default_nettype wire

// ===== rtl/sfdx_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sfdx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sfdx_front.sv =====
// frame parser: accepts bytes, writes payload into the ring, queues finished frames
// depends on sfdx_pkg and serial_frame_deframer_xor_defines.svh
`default_nettype none
`include "serial_frame_deframer_xor_defines.svh"

module sfdx_front #(
   parameter int BUF_DEPTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic [7:0]                      req_rx_byte,
   output logic                                 req_full,
   input  wire logic                            csr_we,
   input  wire logic                            csr_wdata,
   input  wire sfdx_pkg::desc_status_type       desc_stat,
   input  wire sfdx_pkg::back_req_type          back_req,
   output logic                                 ram_we,
   output logic [$clog2(2*BUF_DEPTH)-1:0]       ram_waddr,
   output logic [7:0]                           ram_wdata,
   output logic                                 desc_push,
   output logic [$clog2(BUF_DEPTH+1):0]         desc_data
);

   localparam int RING_DEPTH = 2 * BUF_DEPTH;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int LEN_W      = $clog2(BUF_DEPTH + 1);
   localparam int USED_W     = $clog2(RING_DEPTH + 1);

   sfdx_pkg::parse_state_type state_ff, state_in;
   logic [7:0]         declared_ff, declared_in;
   logic [LEN_W-1:0]   stored_ff, stored_in;
   logic [7:0]         rxor_ff, rxor_in;
   logic [7:0]         recv_ff, recv_in;
   logic [RING_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RING_AW-1:0] commit_ff, commit_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic               enforce_ff;
   logic               rollback;
   logic               accept;
   logic [LEN_W-1:0]   stored_inc;
   logic [RING_AW-1:0] wr_ptr_inc;

   assign req_full   = (used_ff == USED_W'(RING_DEPTH)) || desc_stat.full;
   assign accept     = req_push && !req_full;
   assign stored_inc = stored_ff + LEN_W'(1);
   assign wr_ptr_inc = (wr_ptr_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + RING_AW'(1);
   assign ram_waddr  = wr_ptr_ff;
   assign ram_wdata  = req_rx_byte;
   assign desc_data  = {recv_ff == rxor_ff, LEN_W'(declared_ff)};

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (state_ff)
            sfdx_pkg::PS_HDR1: begin
               if (req_rx_byte == sfdx_pkg::HDR1_BYTE) begin
                  state_in = sfdx_pkg::PS_HDR2;
               end
            end
            sfdx_pkg::PS_HDR2: begin
               if (req_rx_byte == sfdx_pkg::HDR2_BYTE) begin
                  state_in = sfdx_pkg::PS_LEN;
               end else if (req_rx_byte != sfdx_pkg::HDR1_BYTE) begin
                  state_in = sfdx_pkg::PS_HDR1;
               end
            end
            sfdx_pkg::PS_LEN: begin
               state_in = (req_rx_byte == 8'd0) ? sfdx_pkg::PS_XOR : sfdx_pkg::PS_DATA;
            end
            sfdx_pkg::PS_DATA: begin
               if (stored_ff < LEN_W'(BUF_DEPTH)) begin
                  if (8'(stored_inc) == declared_ff) begin
                     state_in = sfdx_pkg::PS_XOR;
                  end
               end else begin
                  state_in = sfdx_pkg::PS_HDR1;
               end
            end
            sfdx_pkg::PS_XOR: begin
               if (enforce_ff && (req_rx_byte != rxor_ff)) begin
                  state_in = sfdx_pkg::PS_HDR1;
               end else begin
                  state_in = sfdx_pkg::PS_FOOT;
               end
            end
            sfdx_pkg::PS_FOOT: begin
               if (req_rx_byte == sfdx_pkg::HDR1_BYTE) begin
                  state_in = sfdx_pkg::PS_HDR2;
               end else begin
                  state_in = sfdx_pkg::PS_HDR1;
               end
            end
            default: begin
               state_in = sfdx_pkg::PS_HDR1;
            end
         endcase
      end
   end

   // datapath actions
   always_comb begin
      ram_we      = 1'b0;
      desc_push   = 1'b0;
      rollback    = 1'b0;
      declared_in = declared_ff;
      stored_in   = stored_ff;
      rxor_in     = rxor_ff;
      recv_in     = recv_ff;
      wr_ptr_in   = wr_ptr_ff;
      commit_in   = commit_ff;
      if (accept) begin
         unique case (state_ff)
            sfdx_pkg::PS_HDR2: begin
               if (req_rx_byte == sfdx_pkg::HDR2_BYTE) begin
                  rxor_in = 8'd0;
               end
            end
            sfdx_pkg::PS_LEN: begin
               // drop bytes left over from an abandoned frame
               declared_in = req_rx_byte;
               stored_in   = '0;
               wr_ptr_in   = commit_ff;
               rollback    = 1'b1;
            end
            sfdx_pkg::PS_DATA: begin
               if (stored_ff < LEN_W'(BUF_DEPTH)) begin
                  ram_we    = 1'b1;
                  wr_ptr_in = wr_ptr_inc;
                  stored_in = stored_inc;
                  rxor_in   = rxor_ff ^ req_rx_byte;
               end
            end
            sfdx_pkg::PS_XOR: begin
               recv_in = req_rx_byte;
            end
            sfdx_pkg::PS_FOOT: begin
               if (req_rx_byte == sfdx_pkg::FOOT_BYTE) begin
                  desc_push = 1'b1;
                  commit_in = wr_ptr_ff;
                  stored_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign used_in = used_ff + USED_W'(ram_we)
                    - (rollback ? USED_W'(stored_ff) : USED_W'(0))
                    - USED_W'(back_req.rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sfdx_pkg::PS_HDR1;
         declared_ff <= 8'd0;
         stored_ff   <= '0;
         rxor_ff     <= 8'd0;
         recv_ff     <= 8'd0;
         wr_ptr_ff   <= '0;
         commit_ff   <= '0;
         used_ff     <= '0;
         enforce_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         declared_ff <= declared_in;
         stored_ff   <= stored_in;
         rxor_ff     <= rxor_in;
         recv_ff     <= recv_in;
         wr_ptr_ff   <= wr_ptr_in;
         commit_ff   <= commit_in;
         used_ff     <= used_in;
         if (csr_we) begin
            enforce_ff <= csr_wdata;
         end
      end
   end

   `SFDX_ASSERT_IMP(a_ring_no_overrun, ram_we, used_ff < USED_W'(RING_DEPTH), "ring overrun")
   `SFDX_ASSERT_IMP(a_rollback_in_range, rollback, used_ff >= USED_W'(stored_ff),
                    "rollback exceeds ring occupancy")

endmodule

`default_nettype wire

// ===== rtl/sfdx_desc_queue.sv =====
// short queue of finished frame descriptors between parser and readout
// depends on sfdx_pkg and serial_frame_deframer_xor_defines.svh
`default_nettype none
`include "serial_frame_deframer_xor_defines.svh"

module sfdx_desc_queue #(
   parameter int WIDTH = 7
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [WIDTH-1:0]          push_data,
   input  wire sfdx_pkg::back_req_type    back_req,
   output sfdx_pkg::desc_status_type      status,
   output logic [WIDTH-1:0]               head_data
);

   logic [WIDTH-1:0]                 entry_ff [sfdx_pkg::DESC_DEPTH];
   logic [sfdx_pkg::DESC_AW-1:0]     wp_ff, rp_ff;
   logic [sfdx_pkg::DESC_CW-1:0]     count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == sfdx_pkg::DESC_CW'(sfdx_pkg::DESC_DEPTH));
   assign head_data    = entry_ff[rp_ff];
   assign count_in     = count_ff + sfdx_pkg::DESC_CW'(push)
                         - sfdx_pkg::DESC_CW'(back_req.desc_pop);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + sfdx_pkg::DESC_AW'(1);
         end
         if (back_req.desc_pop) begin
            rp_ff <= rp_ff + sfdx_pkg::DESC_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   `SFDX_ASSERT_IMP(a_desc_pop_nonempty, back_req.desc_pop, count_ff != '0,
                    "descriptor pop while empty")

endmodule

`default_nettype wire

// ===== rtl/sfdx_back.sv =====
// frame readout: walks queued frames, reads the ring, buffers results for the receiver
// depends on sfdx_pkg and serial_frame_deframer_xor_defines.svh
`default_nettype none
`include "serial_frame_deframer_xor_defines.svh"

module sfdx_back #(
   parameter int BUF_DEPTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sfdx_pkg::desc_status_type       desc_stat,
   input  wire logic [$clog2(BUF_DEPTH+1):0]    desc_head,
   output sfdx_pkg::back_req_type               back_req,
   output logic [$clog2(2*BUF_DEPTH)-1:0]       ram_raddr,
   input  wire logic [7:0]                      ram_rdata,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [7:0]                           rsp_payload_byte,
   output logic [4:0]                           rsp_byte_index,
   output logic [5:0]                           rsp_frame_length,
   output logic                                 rsp_checksum_ok,
   output logic                                 rsp_last
);

   localparam int RING_DEPTH = 2 * BUF_DEPTH;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int LEN_W      = $clog2(BUF_DEPTH + 1);

   logic [RING_AW-1:0] rd_ptr_ff;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   hd_len;
   logic               hd_ok;
   logic               hd_zero;
   logic               pop_fire;
   logic [1:0]         credit;
   logic               issue;

   logic               s1_valid_ff;
   logic [LEN_W-1:0]   s1_idx_ff;
   logic [LEN_W-1:0]   s1_len_ff;
   logic               s1_ok_ff;
   logic               s1_last_ff;
   logic               s1_zero_ff;

   sfdx_pkg::out_item_type out_q_ff [2];
   sfdx_pkg::out_item_type out_item;
   logic               out_wp_ff, out_rp_ff;
   logic [1:0]         out_count_ff;

   assign hd_len   = desc_head[LEN_W-1:0];
   assign hd_ok    = desc_head[LEN_W];
   assign hd_zero  = (hd_len == '0);
   assign pop_fire = rsp_pop && !rsp_empty;
   assign credit   = out_count_ff + {1'b0, s1_valid_ff};
   assign issue    = !desc_stat.empty
                     && ((credit == 2'd0) || (credit == 2'd1) || pop_fire);

   assign back_req.rd       = issue && !hd_zero;
   assign back_req.desc_pop = issue && (hd_zero || (idx_ff + LEN_W'(1) == hd_len));
   assign ram_raddr         = rd_ptr_ff;

   always_comb begin
      idx_in = idx_ff;
      if (back_req.desc_pop) begin
         idx_in = '0;
      end else if (back_req.rd) begin
         idx_in = idx_ff + LEN_W'(1);
      end
   end

   always_comb begin
      out_item.payload_byte = s1_zero_ff ? 8'd0 : ram_rdata;
      out_item.byte_index   = 5'(s1_idx_ff);
      out_item.frame_length = 6'(s1_len_ff);
      out_item.checksum_ok  = s1_ok_ff;
      out_item.last         = s1_last_ff;
   end

   assign rsp_empty        = (out_count_ff == 2'd0);
   assign rsp_payload_byte = out_q_ff[out_rp_ff].payload_byte;
   assign rsp_byte_index   = out_q_ff[out_rp_ff].byte_index;
   assign rsp_frame_length = out_q_ff[out_rp_ff].frame_length;
   assign rsp_checksum_ok  = out_q_ff[out_rp_ff].checksum_ok;
   assign rsp_last         = out_q_ff[out_rp_ff].last;

   // payload registers
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_idx_ff  <= idx_ff;
         s1_len_ff  <= hd_len;
         s1_ok_ff   <= hd_ok;
         s1_last_ff <= back_req.desc_pop;
         s1_zero_ff <= hd_zero;
      end
      if (s1_valid_ff) begin
         out_q_ff[out_wp_ff] <= out_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_wp_ff    <= 1'b0;
         out_rp_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         if (back_req.rd) begin
            rd_ptr_ff <= (rd_ptr_ff == RING_AW'(RING_DEPTH - 1)) ? '0
                         : rd_ptr_ff + RING_AW'(1);
         end
         idx_ff      <= idx_in;
         s1_valid_ff <= issue;
         if (s1_valid_ff) begin
            out_wp_ff <= !out_wp_ff;
         end
         if (pop_fire) begin
            out_rp_ff <= !out_rp_ff;
         end
         out_count_ff <= out_count_ff + {1'b0, s1_valid_ff} - {1'b0, pop_fire};
      end
   end

   `SFDX_ASSERT(a_out_no_overflow, credit != 2'd3, "result buffer overcommitted")

endmodule

`default_nettype wire

// ===== rtl/serial_frame_deframer_xor.sv =====
// serial frame deframer with xor check, top level
// depends on sfdx_pkg, sfdx_ram, sfdx_front, sfdx_desc_queue, sfdx_back
//
// bytes from a serial link enter through a queue port (req_push / req_full) and
// are parsed for frames A5 5A len payload xor EE, one per cycle unless req_full.
// payload bytes go into a ring of 2*BUF_DEPTH bytes; a frame with a good footer
// is queued as a descriptor (up to 4 frames) for the readout side.
// results leave through a queue port (rsp_empty / rsp_pop), one per payload
// byte, or a single empty result for a zero-length frame. the first result
// of a frame passes the descriptor queue and the ring read / s1 registers into
// the result buffer; later ones follow at one per cycle while the receiver pops.
// when the receiver stalls, a two-entry result buffer fills, then the ring and
// descriptor queue fill; req_full rises when the ring is full or four frames
// are waiting, and bytes resume as soon as space frees up.
// csr_we writes checksum_enforce from csr_wdata.
// reset is synchronous: parser waits for a header, all queues empty, enforce
// off. the ring holds no state that needs clearing.
`default_nettype none

module serial_frame_deframer_xor #(
   parameter int BUF_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_payload_byte,
   output logic [4:0]      rsp_byte_index,
   output logic [5:0]      rsp_frame_length,
   output logic            rsp_checksum_ok,
   output logic            rsp_last,
   input  wire logic       csr_we,
   input  wire logic       csr_wdata
);

   localparam int RING_DEPTH = 2 * BUF_DEPTH;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int LEN_W      = $clog2(BUF_DEPTH + 1);

   sfdx_pkg::desc_status_type desc_stat;
   sfdx_pkg::back_req_type    back_req;
   logic                      ram_we;
   logic [RING_AW-1:0]        ram_waddr;
   logic [7:0]                ram_wdata;
   logic [RING_AW-1:0]        ram_raddr;
   logic [7:0]                ram_rdata;
   logic                      desc_push;
   logic [LEN_W:0]            desc_data;
   logic [LEN_W:0]            desc_head;

   sfdx_front #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .desc_stat   (desc_stat),
      .back_req    (back_req),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .desc_push   (desc_push),
      .desc_data   (desc_data)
   );

   sfdx_ram #(
      .WIDTH(8),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (back_req.rd),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sfdx_desc_queue #(
      .WIDTH(LEN_W + 1)
   ) u_desc (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_data),
      .back_req  (back_req),
      .status    (desc_stat),
      .head_data (desc_head)
   );

   sfdx_back #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .desc_stat        (desc_stat),
      .desc_head        (desc_head),
      .back_req         (back_req),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== dv/tb_serial_frame_deframer_xor.sv =====
// self-checking testbench for serial_frame_deframer_xor: byte feed driver, result monitor
// predicts each frame readout from the accepted bytes and compares every result field in order
// depends on sfdx_pkg and the serial_frame_deframer_xor rtl
`default_nettype none

module tb_serial_frame_deframer_xor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_DEPTH   = 32;
   localparam int SETTLE      = 10;
   localparam int STALL_LIMIT = 2000;
   localparam int IDLE_PCT    = 31;
   localparam int BURST_LO    = 70;
   localparam int BURST_HI    = 110;

   typedef enum logic [1:0] {
      FEED_BYTE,
      FEED_CSR,
      FEED_DRAIN
   } feed_kind_type;

   typedef struct packed {
      feed_kind_type kind;
      logic [7:0]    value;
   } feed_entry_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_pop     = 1'b0;
   logic       csr_we      = 1'b0;
   logic       csr_wdata   = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [7:0] rsp_payload_byte;
   logic [4:0] rsp_byte_index;
   logic [5:0] rsp_frame_length;
   logic       rsp_checksum_ok;
   logic       rsp_last;

   feed_entry_type          pending_bytes[$];
   sfdx_pkg::out_item_type  expected_readout[$];

   // predictor state
   sfdx_pkg::parse_state_type track_state  = sfdx_pkg::PS_HDR1;
   logic [7:0]                frame_buf[BUF_DEPTH];
   int                        buf_count    = 0;
   logic [7:0]                len_declared = 8'h00;
   logic [7:0]                xor_acc      = 8'h00;
   logic [7:0]                xor_rx       = 8'h00;
   logic                      enforce_xor  = 1'b0;

   int   bytes_sent   = 0;
   int   quiet_cycles = 0;
   int   stall_cycles = 0;
   int   errors       = 0;
   logic burst_mode;

   assign burst_mode = (bytes_sent >= BURST_LO) && (bytes_sent < BURST_HI);

   serial_frame_deframer_xor #(
      .BUF_DEPTH(BUF_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic deframe_byte(input logic [7:0] b);
      sfdx_pkg::out_item_type item;
      int                     n;
      logic                   ok;
      case (track_state)
         sfdx_pkg::PS_HDR1: begin
            if (b == sfdx_pkg::HDR1_BYTE) track_state = sfdx_pkg::PS_HDR2;
         end
         sfdx_pkg::PS_HDR2: begin
            if (b == sfdx_pkg::HDR2_BYTE) begin
               xor_acc     = 8'h00;
               track_state = sfdx_pkg::PS_LEN;
            end else if (b != sfdx_pkg::HDR1_BYTE) begin
               track_state = sfdx_pkg::PS_HDR1;
            end
         end
         sfdx_pkg::PS_LEN: begin
            len_declared = b;
            buf_count    = 0;
            if (b == 8'h00) track_state = sfdx_pkg::PS_XOR;
            else track_state = sfdx_pkg::PS_DATA;
         end
         sfdx_pkg::PS_DATA: begin
            if (buf_count < BUF_DEPTH) begin
               frame_buf[buf_count] = b;
               buf_count++;
               xor_acc = xor_acc ^ b;
               if (buf_count == int'(len_declared)) track_state = sfdx_pkg::PS_XOR;
            end else begin
               track_state = sfdx_pkg::PS_HDR1;
            end
         end
         sfdx_pkg::PS_XOR: begin
            xor_rx = b;
            if (enforce_xor && (xor_rx != xor_acc)) track_state = sfdx_pkg::PS_HDR1;
            else track_state = sfdx_pkg::PS_FOOT;
         end
         sfdx_pkg::PS_FOOT: begin
            if (b == sfdx_pkg::FOOT_BYTE) begin
               track_state = sfdx_pkg::PS_HDR1;
               ok = (xor_rx == xor_acc);
               n  = (int'(len_declared) > BUF_DEPTH) ? BUF_DEPTH : int'(len_declared);
               if (n == 0) begin
                  item.payload_byte = 8'h00;
                  item.byte_index   = 5'd0;
                  item.frame_length = 6'd0;
                  item.checksum_ok  = ok;
                  item.last         = 1'b1;
                  expected_readout.push_back(item);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     item.payload_byte = frame_buf[i];
                     item.byte_index   = i[4:0];
                     item.frame_length = n[5:0];
                     item.checksum_ok  = ok;
                     item.last         = (i + 1 == n);
                     expected_readout.push_back(item);
                  end
               end
            end else if (b == sfdx_pkg::HDR1_BYTE) begin
               track_state = sfdx_pkg::PS_HDR2;
            end else begin
               track_state = sfdx_pkg::PS_HDR1;
            end
         end
         default: track_state = sfdx_pkg::PS_HDR1;
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(4))
         0: return sfdx_pkg::HDR1_BYTE;
         1: return sfdx_pkg::HDR2_BYTE;
         2: return sfdx_pkg::FOOT_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_entry(input feed_kind_type kind, input logic [7:0] value);
      feed_entry_type e;
      e.kind  = kind;
      e.value = value;
      pending_bytes.push_back(e);
   endtask

   // fill < 0 gives random payload, else every payload byte is fill
   task automatic queue_frame(input int len, input bit bad_xor, input logic [7:0] footer,
                              input int fill);
      logic [7:0] chk;
      logic [7:0] b;
      int         stored;
      chk    = 8'h00;
      stored = (len > BUF_DEPTH) ? BUF_DEPTH : len;
      queue_entry(FEED_BYTE, sfdx_pkg::HDR1_BYTE);
      queue_entry(FEED_BYTE, sfdx_pkg::HDR2_BYTE);
      queue_entry(FEED_BYTE, len[7:0]);
      for (int i = 0; i < stored; i++) begin
         b   = (fill < 0) ? 8'($urandom) : fill[7:0];
         chk = chk ^ b;
         queue_entry(FEED_BYTE, b);
      end
      if (len > BUF_DEPTH) begin
         // overlong: the byte after a full buffer aborts the frame
         queue_entry(FEED_BYTE, pick_byte());
      end else begin
         if (bad_xor) chk = chk ^ 8'($urandom_range(1, 255));
         queue_entry(FEED_BYTE, chk);
         queue_entry(FEED_BYTE, footer);
      end
   endtask

   // byte feed driver
   always @(posedge clock) begin : feed_driver
      logic       next_push;
      logic [7:0] next_byte;
      logic       next_we;
      logic       next_wdata;
      next_push  = req_push;
      next_byte  = req_rx_byte;
      next_we    = 1'b0;
      next_wdata = csr_wdata;
      if (reset) begin
         track_state  = sfdx_pkg::PS_HDR1;
         buf_count    = 0;
         len_declared = 8'h00;
         xor_acc      = 8'h00;
         xor_rx       = 8'h00;
         enforce_xor  = 1'b0;
         quiet_cycles = 0;
         next_push    = 1'b0;
      end else begin
         if (req_push && !req_full) begin
            deframe_byte(req_rx_byte);
            void'(pending_bytes.pop_front());
            bytes_sent++;
         end
         if (csr_we) begin
            enforce_xor = csr_wdata;
            void'(pending_bytes.pop_front());
         end
         if (expected_readout.size() != 0 || req_push || !rsp_empty || csr_we) quiet_cycles = 0;
         else quiet_cycles++;
         if (!(req_push && req_full) && !csr_we) begin
            next_push = 1'b0;
            if (pending_bytes.size() != 0) begin
               case (pending_bytes[0].kind)
                  FEED_BYTE: begin
                     if (burst_mode || ($urandom_range(99) >= IDLE_PCT)) begin
                        next_push = 1'b1;
                        next_byte = pending_bytes[0].value;
                     end
                  end
                  FEED_CSR: begin
                     if (quiet_cycles >= SETTLE) begin
                        next_we    = 1'b1;
                        next_wdata = pending_bytes[0].value[0];
                     end
                  end
                  default: begin
                     if (quiet_cycles >= SETTLE) void'(pending_bytes.pop_front());
                  end
               endcase
            end
         end
      end
      req_push    <= next_push;
      req_rx_byte <= next_byte;
      csr_we      <= next_we;
      csr_wdata   <= next_wdata;
   end

   // result monitor
   always @(posedge clock) begin : readout_monitor
      sfdx_pkg::out_item_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_readout.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h %0d %0d %0b %0b",
                        $time, rsp_payload_byte, rsp_byte_index, rsp_frame_length,
                        rsp_checksum_ok, rsp_last);
               errors++;
            end else begin
               want = expected_readout.pop_front();
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("byte_index", want.byte_index, rsp_byte_index);
               check_field("frame_length", want.frame_length, rsp_frame_length);
               check_field("checksum_ok", want.checksum_ok, rsp_checksum_ok);
               check_field("last", want.last, rsp_last);
            end
         end
         rsp_pop <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // directed part, enforce off after reset
      queue_frame(0, 1'b0, sfdx_pkg::FOOT_BYTE, -1);
      queue_entry(FEED_BYTE, sfdx_pkg::HDR1_BYTE);
      queue_entry(FEED_BYTE, sfdx_pkg::HDR1_BYTE);
      queue_frame(2, 1'b0, sfdx_pkg::FOOT_BYTE, 8'hFF);
      queue_frame(1, 1'b0, sfdx_pkg::HDR1_BYTE, 8'h00);
      queue_frame(2, 1'b1, sfdx_pkg::FOOT_BYTE, -1);
      queue_frame(1, 1'b0, 8'h3C, -1);
      queue_entry(FEED_CSR, 8'h01);
      queue_frame(1, 1'b1, sfdx_pkg::FOOT_BYTE, -1);
      queue_frame(0, 1'b1, sfdx_pkg::FOOT_BYTE, -1);
      queue_frame(1, 1'b0, sfdx_pkg::FOOT_BYTE, 8'h00);

      // full buffer with enforce on, then an overlong frame with enforce off
      queue_frame(BUF_DEPTH, 1'b0, sfdx_pkg::FOOT_BYTE, -1);
      queue_entry(FEED_DRAIN, 8'h00);
      queue_entry(FEED_CSR, 8'h00);
      queue_frame($urandom_range(BUF_DEPTH + 1, 255), 1'b0, sfdx_pkg::FOOT_BYTE, -1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_push || csr_we) @(posedge clock);
      while (expected_readout.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/sfdx_pkg.sv
rtl/sfdx_ram.sv
rtl/sfdx_front.sv
rtl/sfdx_desc_queue.sv
rtl/sfdx_back.sv
rtl/serial_frame_deframer_xor.sv
dv/tb_serial_frame_deframer_xor.sv
